FILE: src/priority_task_scheduler_alarms_defines.svh
// Assertion macros for the scheduler block.
// PTS_ASSERT checks on the rising clock edge outside reset.
// PTS_ASSERT_NR checks on every rising clock edge, reset included.
`ifndef PRIORITY_TASK_SCHEDULER_ALARMS_DEFINES_SVH
`define PRIORITY_TASK_SCHEDULER_ALARMS_DEFINES_SVH

`ifndef SYNTH
`define PTS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("scheduler assertion failed");
`define PTS_ASSERT_NR(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("scheduler assertion failed");
`else
`define PTS_ASSERT(label, prop)
`define PTS_ASSERT_NR(label, prop)
`endif

`endif

FILE: src/pts_pkg.sv
`default_nettype none

package pts_pkg;

    // Fixed register slot counts and field widths
    localparam int SLOT_W      = 3;
    localparam int ASLOT_W     = 2;
    localparam int TASK_SLOTS  = 8;
    localparam int ALARM_SLOTS = 4;
    localparam int PRIO_FIELD  = 8;
    localparam int TIME_FIELD  = 16;
    localparam int TGT_FIELD   = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // Task states as stored in the task memory
    typedef logic [1:0] t_tstate;
    localparam t_tstate ST_SUSP  = 2'd0;
    localparam t_tstate ST_READY = 2'd1;
    localparam t_tstate ST_RUN   = 2'd2;

    // Request codes
    typedef logic [2:0] t_req_kind;
    localparam t_req_kind REQ_START     = 3'd0;
    localparam t_req_kind REQ_ACTIVATE  = 3'd1;
    localparam t_req_kind REQ_CHAIN     = 3'd2;
    localparam t_req_kind REQ_TERMINATE = 3'd3;
    localparam t_req_kind REQ_TICK      = 3'd4;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PRIO     = 3'd0;
    localparam t_cfg_idx CFG_PRESENT  = 3'd1;
    localparam t_cfg_idx CFG_AUTOST   = 3'd2;
    localparam t_cfg_idx CFG_APERIOD  = 3'd3;
    localparam t_cfg_idx CFG_ATARGET  = 3'd4;
    localparam t_cfg_idx CFG_AENABLE  = 3'd5;

    typedef struct packed {
        t_req_kind           req_type;
        logic [SLOT_W-1:0]   task_index;
    } t_req;

    typedef struct packed {
        logic                      running_valid;
        logic [SLOT_W-1:0]         running_task;
        logic [2*TASK_SLOTS-1:0]   task_states;
        logic [ALARM_SLOTS-1:0]    alarms_fired;
        logic                      target_missing;
    } t_result;

    // Scan control from the sequencer to the picker
    typedef struct packed {
        logic              clear;
        logic              take;
        logic [SLOT_W-1:0] idx;
    } t_scan_ctl;

    // Best ready task found by the scan
    typedef struct packed {
        logic              vld;
        logic [SLOT_W-1:0] idx;
    } t_pick;

endpackage

`default_nettype wire

FILE: src/pts_ram.sv
`default_nettype none

// Simple dual-port RAM, one write port, one registered read port
module pts_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: src/pts_picker.sv
`default_nettype none

// Walks the task states as they come out of the task memory, builds the
// packed state vector and keeps the best ready task (higher priority,
// lower index on a tie).
module pts_picker #(
    parameter int NUM_SLOTS = 8,
    parameter int PRIO_BITS = 8
) (
    input  wire logic                                               i_clk,
    input  wire logic                                               i_rst_n,
    input  wire pts_pkg::t_scan_ctl                                 i_ctl,
    input  wire pts_pkg::t_tstate                                   i_state,
    input  wire logic [pts_pkg::TASK_SLOTS*pts_pkg::PRIO_FIELD-1:0] i_prios,
    input  wire logic [pts_pkg::TASK_SLOTS-1:0]                     i_present,
    output logic      [2*pts_pkg::TASK_SLOTS-1:0]                   o_states,
    output pts_pkg::t_pick                                          o_best
);

    import pts_pkg::*;

    logic [PRIO_BITS-1:0]     prio;
    logic                     cand;
    logic                     better;
    logic                     r_best_vld;
    logic [SLOT_W-1:0]        r_best_idx;
    logic [PRIO_BITS-1:0]     r_best_prio;
    logic [2*TASK_SLOTS-1:0]  r_states;

    // candidate: present, in range and ready; strict compare keeps lowest index
    assign prio   = i_prios[PRIO_FIELD*i_ctl.idx +: PRIO_BITS];
    assign cand   = i_ctl.take && (int'(i_ctl.idx) < NUM_SLOTS) &&
                    i_present[i_ctl.idx] && (i_state == ST_READY);
    assign better = cand && (!r_best_vld || (prio > r_best_prio));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_vld <= 1'b0;
        end else if (i_ctl.clear) begin
            r_best_vld <= 1'b0;
        end else if (better) begin
            r_best_vld <= 1'b1;
        end
    end

    // payload of the scan
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_states <= '0;
        end else if (i_ctl.take) begin
            r_states[2*i_ctl.idx +: 2] <= i_state;
        end
        if (better) begin
            r_best_idx  <= i_ctl.idx;
            r_best_prio <= prio;
        end
    end

    assign o_states = r_states;
    assign o_best   = '{vld: r_best_vld, idx: r_best_idx};

endmodule

`default_nettype wire

FILE: src/priority_task_scheduler_alarms.sv
`default_nettype none
`include "priority_task_scheduler_alarms_defines.svh"

// Fixed-priority task scheduler with periodic alarms.
// Requests (start, activate, chain, terminate, tick) enter on i_req when start
// is high and busy is low. Each request gives one result on o_result, shown for
// one cycle with o_result_valid; the receiver cannot stall it. A new request
// can be taken in the cycle the result is shown.
// Task states and alarm counts live in two small synchronous RAMs; every
// request other than an unknown code updates them and then scans all
// N = min(NUM_TASKS, 8) task entries, one per cycle; an unknown code only scans.
// The task memory read port sets the pace: one task state per cycle.
// Configuration writes go on i_cfg_valid / i_cfg_index / i_cfg_data; ready is
// always high, and writes are meant to land while the block is idle.
// After reset a clearing pass writes every task suspended and every alarm
// count to zero; busy stays high during it.
module priority_task_scheduler_alarms #(
    parameter int NUM_TASKS  = 8,
    parameter int NUM_ALARMS = 4,
    parameter int PRIO_BITS  = 8,
    parameter int TIME_BITS  = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire pts_pkg::t_req                      i_req,
    output logic                                    o_result_valid,
    output pts_pkg::t_result                        o_result,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [pts_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import pts_pkg::*;

    localparam int TASKS_USED  = (NUM_TASKS < TASK_SLOTS) ? NUM_TASKS : TASK_SLOTS;
    localparam int ALARMS_USED = (NUM_ALARMS < ALARM_SLOTS) ? NUM_ALARMS : ALARM_SLOTS;
    localparam int TASK_AW     = $clog2(TASKS_USED);
    localparam int ALM_AW      = (ALARMS_USED > 1) ? $clog2(ALARMS_USED) : 1;
    localparam int SWEEP       = (TASKS_USED > ALARMS_USED) ? TASKS_USED : ALARMS_USED;
    localparam int CNT_W       = $clog2(SWEEP + 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LEAVE, S_TARGET, S_ALARM, S_SCAN, S_PICK
    } t_fsm;

    // configuration registers
    logic [TASK_SLOTS*PRIO_FIELD-1:0]   r_prios;
    logic [TASK_SLOTS-1:0]              r_present;
    logic [TASK_SLOTS-1:0]              r_autostart;
    logic [ALARM_SLOTS*TIME_FIELD-1:0]  r_periods;
    logic [ALARM_SLOTS*TGT_FIELD-1:0]   r_targets;
    logic [ALARM_SLOTS-1:0]             r_enables;

    // sequencer state
    t_fsm                    r_state;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_dv;
    logic [CNT_W-1:0]        r_di;
    logic                    r_is_start;
    logic                    r_do_sched;
    t_req_kind               r_kind;
    logic [SLOT_W-1:0]       r_idx;
    logic [ALARM_SLOTS-1:0]  r_fired;
    logic                    r_missing;
    logic                    r_run_valid;
    logic [SLOT_W-1:0]       r_run_index;
    logic                    r_out_valid;
    t_result                 r_result;

    // memory ports
    logic                    tmem_we;
    logic [TASK_AW-1:0]      tmem_waddr;
    t_tstate                 tmem_wdata;
    logic [TASK_AW-1:0]      tmem_raddr;
    t_tstate                 tmem_rdata;
    logic                    amem_we;
    logic [ALM_AW-1:0]       amem_waddr;
    logic [TIME_BITS-1:0]    amem_wdata;
    logic [ALM_AW-1:0]       amem_raddr;
    logic [TIME_BITS-1:0]    amem_rdata;

    // alarm step
    logic [ASLOT_W-1:0]      a_idx;
    logic                    a_en;
    logic [TIME_BITS-1:0]    a_period;
    logic [TIME_BITS:0]      a_next;
    logic [SLOT_W-1:0]       a_tgt;
    logic                    alm_fire;

    // scan and pick
    t_scan_ctl               scan_ctl;
    t_pick                   best;
    logic [2*TASK_SLOTS-1:0] pick_states;
    logic [2*TASK_SLOTS-1:0] states_out;
    logic                    pick_now;
    logic                    res_run_valid;
    logic [SLOT_W-1:0]       res_run_index;
    logic                    issue_task;
    logic                    issue_alm;

    function automatic logic f_exists(input logic [SLOT_W-1:0] idx);
        return (int'(idx) < TASKS_USED) && r_present[idx];
    endfunction

    pts_ram #(.WIDTH(2), .DEPTH(TASKS_USED)) u_task_mem (
        .i_clk   (i_clk),
        .i_we    (tmem_we),
        .i_waddr (tmem_waddr),
        .i_wdata (tmem_wdata),
        .i_raddr (tmem_raddr),
        .o_rdata (tmem_rdata)
    );

    pts_ram #(.WIDTH(TIME_BITS), .DEPTH(ALARMS_USED)) u_alarm_mem (
        .i_clk   (i_clk),
        .i_we    (amem_we),
        .i_waddr (amem_waddr),
        .i_wdata (amem_wdata),
        .i_raddr (amem_raddr),
        .o_rdata (amem_rdata)
    );

    pts_picker #(.NUM_SLOTS(TASKS_USED), .PRIO_BITS(PRIO_BITS)) u_picker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (scan_ctl),
        .i_state   (tmem_rdata),
        .i_prios   (r_prios),
        .i_present (r_present),
        .o_states  (pick_states),
        .o_best    (best)
    );

    // alarm fields for the entry whose count is on the read port
    assign a_idx    = ASLOT_W'(r_di);
    assign a_en     = r_enables[a_idx];
    assign a_period = r_periods[TIME_FIELD*a_idx +: TIME_BITS];
    assign a_next   = {1'b0, amem_rdata} + (TIME_BITS+1)'(1);
    assign a_tgt    = r_targets[TGT_FIELD*a_idx +: SLOT_W];

    assign issue_task = int'(r_cnt) < TASKS_USED;
    assign issue_alm  = int'(r_cnt) < ALARMS_USED;

    assign scan_ctl = '{clear: (r_state == S_IDLE),
                        take:  (r_state == S_SCAN) && r_dv,
                        idx:   SLOT_W'(r_di)};
    assign pick_now = (r_state == S_PICK) && r_do_sched && best.vld;

    // result of the pick: a non-scheduling request keeps the running task
    assign res_run_valid = r_do_sched ? best.vld : r_run_valid;
    assign res_run_index = r_do_sched ? (best.vld ? best.idx : '0) : r_run_index;

    always_comb begin
        states_out = pick_states;
        if (pick_now) begin
            states_out[2*best.idx +: 2] = ST_RUN;
        end
    end

    // memory port control per sequencer step
    always_comb begin
        tmem_we    = 1'b0;
        tmem_waddr = TASK_AW'(r_cnt);
        tmem_wdata = ST_SUSP;
        tmem_raddr = TASK_AW'(r_cnt);
        amem_we    = 1'b0;
        amem_waddr = ALM_AW'(r_cnt);
        amem_wdata = '0;
        amem_raddr = ALM_AW'(r_cnt);
        alm_fire   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                // reset clear or start load, one entry of each memory a cycle
                tmem_we    = issue_task;
                tmem_wdata = (r_is_start && f_exists(SLOT_W'(r_cnt)) &&
                              r_autostart[SLOT_W'(r_cnt)]) ? ST_READY : ST_SUSP;
                amem_we    = issue_alm;
            end
            S_LEAVE: begin
                tmem_we    = r_run_valid;
                tmem_waddr = TASK_AW'(r_run_index);
                tmem_wdata = (r_kind == REQ_ACTIVATE) ? ST_READY : ST_SUSP;
            end
            S_TARGET: begin
                tmem_we    = f_exists(r_idx);
                tmem_waddr = TASK_AW'(r_idx);
                tmem_wdata = ST_READY;
            end
            S_ALARM: begin
                // count write-back runs one entry behind the read
                if (r_dv && a_en && (a_period != '0)) begin
                    amem_we    = 1'b1;
                    amem_waddr = ALM_AW'(r_di);
                    if (a_next < {1'b0, a_period}) begin
                        amem_wdata = a_next[TIME_BITS-1:0];
                    end else begin
                        alm_fire = 1'b1;
                        // only the running task holds the run state
                        if (f_exists(a_tgt) && !(r_run_valid && (r_run_index == a_tgt))) begin
                            tmem_we    = 1'b1;
                            tmem_waddr = TASK_AW'(a_tgt);
                            tmem_wdata = ST_READY;
                        end
                    end
                end
            end
            S_PICK: begin
                if (pick_now) begin
                    tmem_we    = 1'b1;
                    tmem_waddr = TASK_AW'(best.idx);
                    tmem_wdata = ST_RUN;
                end
            end
            S_IDLE, S_SCAN: begin
            end
        endcase
    end

    // sequencer, configuration registers and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_dv        <= 1'b0;
            r_is_start  <= 1'b0;
            r_run_valid <= 1'b0;
            r_run_index <= '0;
            r_out_valid <= 1'b0;
            r_prios     <= '0;
            r_present   <= '0;
            r_autostart <= '0;
            r_periods   <= '0;
            r_targets   <= '0;
            r_enables   <= '0;
        end else begin
            r_out_valid <= 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PRIO:    r_prios     <= i_cfg_data;
                    CFG_PRESENT: r_present   <= i_cfg_data[TASK_SLOTS-1:0];
                    CFG_AUTOST:  r_autostart <= i_cfg_data[TASK_SLOTS-1:0];
                    CFG_APERIOD: r_periods   <= i_cfg_data;
                    CFG_ATARGET: r_targets   <= i_cfg_data[ALARM_SLOTS*TGT_FIELD-1:0];
                    CFG_AENABLE: r_enables   <= i_cfg_data[ALARM_SLOTS-1:0];
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                S_CLEAR: begin
                    if (r_cnt == CNT_W'(SWEEP - 1)) begin
                        r_cnt   <= '0;
                        r_state <= r_is_start ? S_SCAN : S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_kind     <= i_req.req_type;
                        r_idx      <= i_req.task_index;
                        r_fired    <= '0;
                        r_missing  <= 1'b0;
                        r_cnt      <= '0;
                        r_dv       <= 1'b0;
                        r_is_start <= 1'b0;
                        r_do_sched <= 1'b1;
                        case (i_req.req_type)
                            REQ_START: begin
                                r_is_start  <= 1'b1;
                                r_run_valid <= 1'b0;
                                r_run_index <= '0;
                                r_state     <= S_CLEAR;
                            end
                            REQ_ACTIVATE, REQ_CHAIN, REQ_TERMINATE: begin
                                r_state <= S_LEAVE;
                            end
                            REQ_TICK: begin
                                r_do_sched <= !r_run_valid;
                                r_state    <= S_ALARM;
                            end
                            default: begin
                                r_do_sched <= 1'b0;
                                r_state    <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_LEAVE: begin
                    r_run_valid <= 1'b0;
                    r_run_index <= '0;
                    r_state     <= (r_kind == REQ_TERMINATE) ? S_SCAN : S_TARGET;
                end
                S_TARGET: begin
                    if (!f_exists(r_idx)) begin
                        r_missing <= 1'b1;
                    end
                    r_state <= S_SCAN;
                end
                S_ALARM: begin
                    r_dv <= issue_alm;
                    r_di <= r_cnt;
                    if (issue_alm) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (alm_fire) begin
                        r_fired[a_idx] <= 1'b1;
                    end
                    if (r_dv && (r_di == CNT_W'(ALARMS_USED - 1))) begin
                        r_cnt   <= '0;
                        r_dv    <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_dv <= issue_task;
                    r_di <= r_cnt;
                    if (issue_task) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_dv && (r_di == CNT_W'(TASKS_USED - 1))) begin
                        r_cnt   <= '0;
                        r_dv    <= 1'b0;
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    r_run_valid <= res_run_valid;
                    r_run_index <= res_run_index;
                    r_result    <= '{running_valid:  res_run_valid,
                                     running_task:   res_run_index,
                                     task_states:    states_out,
                                     alarms_fired:   r_fired,
                                     target_missing: r_missing};
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_result;
    assign o_cfg_ready    = 1'b1;

    // one strobe per request, never back to back
    `PTS_ASSERT(a_single_strobe, o_result_valid |=> !o_result_valid)
    // the reported running-valid flag matches the held run register
    `PTS_ASSERT(a_run_report, o_result_valid |-> (o_result.running_valid == r_run_valid))
    // an accepted request keeps the block busy in the next cycle
    `PTS_ASSERT(a_accept_busy, (start && !busy) |=> busy)
    // reset starts the clearing pass
    `PTS_ASSERT_NR(a_reset_clear, !i_rst_n |=> busy)

endmodule

`default_nettype wire
